// File: rtl/att_pkg.sv
// shared types and constants for the allocation tracking table
// field widths, opcode and status codes, table entry layout
`timescale 1ns / 1ps

package att_pkg;

  localparam int DEFAULT_DEPTH = 64;

  localparam int OP_W     = 2;
  localparam int KEY_W    = 48;
  localparam int LEN_W    = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 16;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_CHECK  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ZERO_KEY  = 2'd3;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [LEN_W-1:0] len;
  } entry_t;

  typedef struct packed {
    logic [COUNT_W-1:0]  entry_count;
    logic [STATUS_W-1:0] status;
  } result_t;

endpackage

// File: rtl/att_entry_ram.sv
// entry storage: one write port, one read port with registered data
// depends on att_pkg for the entry layout
`timescale 1ns / 1ps

module att_entry_ram #(
  parameter int TABLE_DEPTH = att_pkg::DEFAULT_DEPTH,
  parameter int IDX_W       = $clog2(TABLE_DEPTH)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [IDX_W-1:0] wr_addr_i,
  input  att_pkg::entry_t  wr_data_i,
  input  logic [IDX_W-1:0] rd_addr_i,
  output att_pkg::entry_t  rd_data_o
);
  import att_pkg::*;

  entry_t mem [TABLE_DEPTH];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/att_ctrl.sv
// operation sequencer: insert append, linear key scan, swap-remove move
// depends on att_pkg; drives the entry ram ports
`timescale 1ns / 1ps

module att_ctrl #(
  parameter int TABLE_DEPTH = att_pkg::DEFAULT_DEPTH,
  parameter int IDX_W       = $clog2(TABLE_DEPTH)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [att_pkg::OP_W-1:0]   in_op_i,
  input  logic [att_pkg::KEY_W-1:0]  in_key_i,
  input  logic [att_pkg::LEN_W-1:0]  in_len_i,
  output logic [IDX_W-1:0]           rd_addr_o,
  input  att_pkg::entry_t            rd_data_i,
  output logic                       wr_en_o,
  output logic [IDX_W-1:0]           wr_addr_o,
  output att_pkg::entry_t            wr_data_o,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output att_pkg::result_t           res_o
);
  import att_pkg::*;

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_MOVE,
    S_DONE
  } state_e;

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [IDX_W-1:0]    pos_q, pos_d;
  logic [KEY_W-1:0]    key_q, key_d;
  logic                is_check_q, is_check_d;
  logic [STATUS_W-1:0] status_q, status_d;

  logic [CNT_W-1:0] count_m1;
  logic [IDX_W-1:0] last_idx;
  logic             hit;

  assign count_m1 = count_q - CNT_W'(1);
  assign last_idx = count_m1[IDX_W-1:0];
  assign hit      = (rd_data_i.key == key_q);

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    idx_d      = idx_q;
    pos_d      = pos_q;
    key_d      = key_q;
    is_check_d = is_check_q;
    status_d   = status_q;
    rd_addr_o  = '0;
    wr_en_o    = 1'b0;
    wr_addr_o  = count_q[IDX_W-1:0];
    wr_data_o  = '{key: in_key_i, len: in_len_i};

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          key_d      = in_key_i;
          is_check_d = (in_op_i == OP_CHECK);
          idx_d      = '0;
          priority if (in_key_i == '0) begin
            status_d = ST_ZERO_KEY;
            state_d  = S_DONE;
          end else if (in_op_i == OP_INSERT) begin
            if (count_q == CNT_W'(TABLE_DEPTH)) begin
              status_d = ST_FULL;
            end else begin
              wr_en_o  = 1'b1;
              count_d  = count_q + CNT_W'(1);
              status_d = ST_OK;
            end
            state_d = S_DONE;
          end else if (in_op_i == OP_REMOVE || in_op_i == OP_CHECK) begin
            if (count_q == '0) begin
              status_d = ST_NOT_FOUND;
              state_d  = S_DONE;
            end else begin
              state_d = S_SCAN;
            end
          end else begin
            status_d = ST_NOT_FOUND;
            state_d  = S_DONE;
          end
        end
      end
      S_SCAN: begin
        rd_addr_o = idx_q + IDX_W'(1);
        if (hit) begin
          pos_d = idx_q;
          if (is_check_q) begin
            status_d = ST_OK;
            state_d  = S_DONE;
          end else begin
            rd_addr_o = last_idx;
            state_d   = S_MOVE;
          end
        end else if (idx_q == last_idx) begin
          status_d = ST_NOT_FOUND;
          state_d  = S_DONE;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      S_MOVE: begin
        wr_en_o   = (last_idx != pos_q);
        wr_addr_o = pos_q;
        wr_data_o = rd_data_i;
        count_d   = count_m1;
        status_d  = ST_OK;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    pos_q      <= pos_d;
    key_q      <= key_d;
    is_check_q <= is_check_d;
    status_q   <= status_d;
  end

  assign in_ready_o        = (state_q == S_IDLE);
  assign res_valid_o       = (state_q == S_DONE);
  assign res_o.status      = status_q;
  assign res_o.entry_count = COUNT_W'(count_q);

endmodule

// File: rtl/allocation_tracking_table.sv
// top level of the allocation tracking table: stream ports, sequencer, entry ram,
// output register; depends on att_pkg, att_ctrl and att_entry_ram
`timescale 1ns / 1ps

// Keeps up to TABLE_DEPTH live allocations (address key, block length) packed at the
// front of a single-port-read entry memory. One item is worked at a time. Insert,
// zero-key and unused opcodes go straight to the result without a scan. Remove and
// check scan the filled entries one per cycle through the memory read port, stopping
// at the first match or after the last filled entry; a remove that hits then reads
// the last entry and moves it into the freed slot. A finished result sits in an
// output register, and the next transfer is taken while it waits. No clearing pass
// is needed after reset.
module allocation_tracking_table #(
  parameter int TABLE_DEPTH = att_pkg::DEFAULT_DEPTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // opcode[1:0], address_key[49:2], block_length[81:50], zero pad
  input  logic [att_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // status[1:0], entry_count[8:2], zero pad
  output logic [att_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
  import att_pkg::*;

  localparam int IDX_W   = $clog2(TABLE_DEPTH);
  localparam int OUT_PAD = OUT_TDATA_W - COUNT_W - STATUS_W;

  logic [OP_W-1:0]  in_op;
  logic [KEY_W-1:0] in_key;
  logic [LEN_W-1:0] in_len;

  logic [IDX_W-1:0] rd_addr;
  entry_t           rd_data;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;

  logic    res_valid;
  logic    res_ready;
  result_t res;

  logic    out_valid_q, out_valid_d;
  result_t out_res_q;

  assign in_op  = s_axis_tdata[OP_W-1:0];
  assign in_key = s_axis_tdata[OP_W +: KEY_W];
  assign in_len = s_axis_tdata[OP_W+KEY_W +: LEN_W];

  att_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .IDX_W      (IDX_W)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_op_i    (in_op),
    .in_key_i   (in_key),
    .in_len_i   (in_len),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  att_entry_ram #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .IDX_W      (IDX_W)
  ) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  // output register frees up when its transfer completes
  assign res_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_ready) begin
      out_valid_d = res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{OUT_PAD{1'b0}}, out_res_q.entry_count, out_res_q.status};

endmodule

// File: tb/sv/tb.sv
// testbench for the allocation tracking table: directed and random insert, remove
// and check transfers with random stalls on both streams, checked against a table model
// depends on att_pkg and allocation_tracking_table
`timescale 1ns / 1ps

module tb;
  import att_pkg::*;

  localparam int DEPTH = DEFAULT_DEPTH;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int POOL_SIZE = 20;
  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 80;
  localparam int PRESSURE_AT = 150;
  localparam int PRESSURE_CYCLES = 500;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [KEY_W-1:0] key;
    logic [OP_W-1:0]  op;
  } table_req_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  // opcode[1:0], address_key[49:2], block_length[81:50], zero pad
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  // status[1:0], entry_count[8:2], zero pad
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  table_req_t       pending_reqs[$];
  result_t          expected_results[$];
  logic [KEY_W-1:0] key_pool[POOL_SIZE];

  logic [KEY_W-1:0] model_keys[DEPTH];
  logic [LEN_W-1:0] model_lens[DEPTH];
  int               model_fill;

  int error_count;
  int idle_cycles;
  int results_seen;

  table_req_t cur_req;
  int         in_gap;
  bit         in_burst;
  int         out_hold;
  bit         out_burst;
  result_t    got;
  result_t    want;

  allocation_tracking_table #(
    .TABLE_DEPTH(DEPTH)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    $display("tb: mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // index of the first live entry holding the key, model_fill when absent
  function automatic int find_entry(input logic [KEY_W-1:0] key);
    int i;
    for (i = 0; i < model_fill; i++) begin
      if (model_keys[i] == key) return i;
    end
    return model_fill;
  endfunction

  function automatic result_t apply_table_op(input table_req_t req);
    result_t res;
    int pos;
    res.status = ST_NOT_FOUND;
    if (req.key == '0) begin
      res.status = ST_ZERO_KEY;
    end else begin
      case (req.op)
        OP_INSERT: begin
          if (model_fill >= DEPTH) begin
            res.status = ST_FULL;
          end else begin
            model_keys[model_fill] = req.key;
            model_lens[model_fill] = req.len;
            model_fill++;
            res.status = ST_OK;
          end
        end
        OP_REMOVE: begin
          pos = find_entry(req.key);
          if (pos < model_fill) begin
            model_keys[pos] = model_keys[model_fill-1];
            model_lens[pos] = model_lens[model_fill-1];
            model_fill--;
            res.status = ST_OK;
          end
        end
        OP_CHECK: begin
          pos = find_entry(req.key);
          if (pos < model_fill) res.status = ST_OK;
        end
        default: res.status = ST_NOT_FOUND;
      endcase
    end
    res.entry_count = model_fill[COUNT_W-1:0];
    return res;
  endfunction

  task automatic add_req(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                         input logic [LEN_W-1:0] len);
    table_req_t req;
    req.op = op;
    req.key = key;
    req.len = len;
    pending_reqs.push_back(req);
  endtask

  function automatic logic [KEY_W-1:0] random_key();
    int r;
    logic [63:0] wide;
    r = $urandom_range(0, 99);
    wide = {$urandom(), $urandom()};
    if (r < 4) return '0;
    if (r < 20) return wide[KEY_W-1:0];
    return key_pool[$urandom_range(0, POOL_SIZE-1)];
  endfunction

  task automatic add_random_phase(input int count, input bit filling);
    int n;
    int r;
    logic [OP_W-1:0] op;
    for (n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (filling) begin
        op = (r < 75) ? OP_INSERT : (r < 85) ? OP_REMOVE : (r < 95) ? OP_CHECK : OP_UNUSED;
      end else begin
        op = (r < 15) ? OP_INSERT : (r < 75) ? OP_REMOVE : (r < 95) ? OP_CHECK : OP_UNUSED;
      end
      add_req(op, random_key(), $urandom());
    end
  endtask

  initial begin
    logic [63:0] wide;
    int p;
    rst_ni = 1'b0;
    model_fill = 0;
    for (p = 0; p < POOL_SIZE; p++) begin
      wide = {$urandom(), $urandom()};
      key_pool[p] = (wide[KEY_W-1:0] == '0) ? 48'd1 : wide[KEY_W-1:0];
    end
    key_pool[0] = 48'd1;
    key_pool[1] = '1;

    // empty table misses, zero key with every opcode
    add_req(OP_CHECK,  48'd1, '0);
    add_req(OP_REMOVE, 48'd1, '0);
    add_req(OP_INSERT, '0, '1);
    add_req(OP_REMOVE, '0, '0);
    add_req(OP_CHECK,  '0, '0);
    add_req(OP_UNUSED, '0, '1);
    // extremes, duplicate insert
    add_req(OP_INSERT, '1, '1);
    add_req(OP_INSERT, 48'd1, '0);
    add_req(OP_INSERT, 48'd1, 32'd5);
    add_req(OP_INSERT, 48'h5555_5555_5555, 32'hAAAA_AAAA);
    add_req(OP_CHECK,  48'd1, '0);
    add_req(OP_UNUSED, 48'd1, '0);
    // remove with last entry moved, first match, last entry itself
    add_req(OP_REMOVE, '1, '0);
    add_req(OP_REMOVE, 48'd1, '0);
    add_req(OP_CHECK,  48'd1, '0);
    add_req(OP_REMOVE, 48'd1, '0);
    add_req(OP_CHECK,  48'd1, '0);
    add_req(OP_REMOVE, 48'h5555_5555_5555, '0);
    add_req(OP_REMOVE, 48'hAAAA_AAAA_AAAA, '0);
    add_req(OP_CHECK,  '1, '1);

    // fill phases are mostly inserts to push the table toward full, drain phases mostly removes
    add_random_phase(80, 1'b1);
    add_random_phase(60, 1'b0);
    add_random_phase(80, 1'b1);
    add_random_phase(60, 1'b0);
    add_random_phase(80, 1'b1);
    add_random_phase(60, 1'b0);
    add_random_phase(80, 1'b1);
    add_random_phase(50, 1'b0);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      in_gap = 0;
      in_burst = 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        expected_results.push_back(apply_table_op(cur_req));
        if ($urandom_range(0, 31) == 0) in_burst = !in_burst;
        in_gap = in_burst ? 0 : $urandom_range(0, 15);
      end
      if (in_gap == 0 && pending_reqs.size() > 0) begin
        cur_req = pending_reqs.pop_front();
        s_axis_tdata  <= {{(IN_TDATA_W-OP_W-KEY_W-LEN_W){1'b0}}, cur_req};
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
        if (in_gap > 0) in_gap--;
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      out_hold = 3;
      out_burst = 1'b0;
      results_seen = 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata[STATUS_W+COUNT_W-1:0]);
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result status %0d count %0d",
                                  got.status, got.entry_count));
      end else begin
        want = expected_results.pop_front();
        if (got.status != want.status)
          report_mismatch($sformatf("result %0d status %0d, want %0d",
                                    results_seen, got.status, want.status));
        if (got.entry_count != want.entry_count)
          report_mismatch($sformatf("result %0d entry_count %0d, want %0d",
                                    results_seen, got.entry_count, want.entry_count));
      end
      results_seen++;
      if ($urandom_range(0, 31) == 0) out_burst = !out_burst;
      out_hold = out_burst ? 0 : $urandom_range(0, 15);
      // long hold-off so the input side backs up
      if (results_seen == PRESSURE_AT) out_hold = PRESSURE_CYCLES;
      m_axis_tready <= (out_hold == 0);
    end else if (!m_axis_tready) begin
      if (out_hold > 0) out_hold--;
      if (out_hold == 0) m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    error_count = 0;
    @(posedge rst_ni);
    while (!(pending_reqs.size() == 0 && !s_axis_tvalid && expected_results.size() == 0)
           && idle_cycles < IDLE_LIMIT)
      @(posedge clk_i);
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
    end else begin
      repeat (DRAIN_CYCLES) @(posedge clk_i);
      if (error_count == 0) begin
        $display("tb: success");
      end else begin
        $display("tb: failure");
      end
    end
    $finish;
  end

endmodule

// File: files.f
rtl/att_pkg.sv
rtl/att_entry_ram.sv
rtl/att_ctrl.sv
rtl/allocation_tracking_table.sv
tb/sv/tb.sv
